// ===== hdl/utf8_stream_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_macros.svh
// Assertion macros for the UTF-8 stream decoder. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge out of reset
`define UTF8SD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("utf8sd: invariant violated");

// Antecedent at one edge implies consequent at the next edge
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8sd: next-cycle check failed");

`else

`define UTF8SD_ASSERT_ALWAYS(lbl, expr)
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared widths, constants and types of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CP_W         = 21;
  localparam int unsigned PEND_W       = 2;
  localparam int unsigned PAYLOAD_BITS = 6;

  // Code point sent on any decoding error until reconfigured (U+FFFD)
  localparam logic [CP_W-1:0] ERR_VALUE_RST = CP_W'(65533);

  // Sequence state carried from byte to byte
  typedef struct packed {
    logic [CP_W-1:0]   partial;
    logic [PEND_W-1:0] pending;
  } seq_state_t;

  // One result beat
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            error;
    logic            final_result;
  } result_t;

  // Step outcome: next state plus an optional result
  typedef struct packed {
    seq_state_t nxt;
    logic       res_valid;
    result_t    res;
  } step_t;

endpackage

// ===== hdl/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder with error reporting.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+----------------------------------
//   in_      | in  | in_valid / in_ready   | data_byte, end_of_stream
//   out_     | out | out_valid / out_ready | code_point, error, final_result
//   cfg_     | in  | cfg_we (no wait)      | cfg_wdata = error value
//
// One byte per cycle while in_ready is high. A byte's decode runs from the
// state registers into the output stage; with the output register free, a
// result shows in the cycle after its byte is taken. A two-entry output stage
// (register plus skid) lets a byte be taken while a result waits; in_ready
// drops only when both hold a beat. Reset (synchronous, rst_n low) clears the
// sequence state, empties the output stage and restores the error value.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_top_macros.svh"

module utf8_stream_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [utf8sd_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                          in_end_of_stream,
  // code point output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]   out_code_point,
  output logic                          out_error,
  output logic                          out_final_result,
  // configuration
  input  logic                          cfg_we,
  input  logic [utf8sd_pkg::CP_W-1:0]   cfg_wdata
);
  import utf8sd_pkg::*;

  logic [CP_W-1:0] err_value_r;
  seq_state_t      state_r;
  step_t           step;
  result_t         out_r, skid_r;
  logic            out_valid_r, skid_valid_r;
  logic            in_fire, pop, push;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign push     = in_fire && step.res_valid;

  // Error value register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_value_r <= ERR_VALUE_RST;
    end else if (cfg_we) begin
      err_value_r <= cfg_wdata;
    end
  end

  // Per-byte decode
  utf8sd_step u_step (
    .cur           (state_r),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .err_value     (err_value_r),
    .step          (step)
  );

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= step.nxt;
    end
  end

  // Output stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= step.res;
      end else begin
        skid_r <= step.res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = out_r.code_point;
  assign out_error        = out_r.error;
  assign out_final_result = out_r.final_result;

  // Checks
  `UTF8SD_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `UTF8SD_ASSERT_NEXT(a_eos_clears_state, in_fire && in_end_of_stream, state_r.pending == '0)
  `UTF8SD_ASSERT_NEXT(a_eos_gives_result, in_fire && in_end_of_stream, out_valid_r)

endmodule

// ===== hdl/utf8sd_step.sv =====
// ----------------------------------------------------------------------------
// utf8sd_step
// Per-byte decode: classifies the byte against the sequence state and gives
// the next state and an optional result. Pure combinational logic.
// ----------------------------------------------------------------------------
module utf8sd_step (
  input  utf8sd_pkg::seq_state_t           cur,
  input  logic [utf8sd_pkg::BYTE_W-1:0]    data_byte,
  input  logic                             end_of_stream,
  input  logic [utf8sd_pkg::CP_W-1:0]      err_value,
  output utf8sd_pkg::step_t                step
);
  import utf8sd_pkg::*;

  logic [CP_W-1:0] shifted;

  // Append six payload bits of a continuation byte
  assign shifted = {cur.partial[CP_W-PAYLOAD_BITS-1:0], data_byte[PAYLOAD_BITS-1:0]};

  always_comb begin
    step                  = '0;
    step.nxt              = cur;
    step.res.final_result = end_of_stream;

    if (cur.pending == '0) begin
      // Lead byte
      case (data_byte) inside
        8'b0???_????: begin
          step.res_valid      = 1'b1;
          step.res.code_point = CP_W'(data_byte);
          step.nxt            = '0;
        end
        8'b110?_????: begin
          step.nxt.partial = CP_W'(data_byte[4:0]);
          step.nxt.pending = PEND_W'(1);
        end
        8'b1110_????: begin
          step.nxt.partial = CP_W'(data_byte[3:0]);
          step.nxt.pending = PEND_W'(2);
        end
        8'b1111_0???: begin
          step.nxt.partial = CP_W'(data_byte[2:0]);
          step.nxt.pending = PEND_W'(3);
        end
        default: begin
          // stray continuation or 11111xxx
          step.res_valid      = 1'b1;
          step.res.error      = 1'b1;
          step.res.code_point = err_value;
          step.nxt            = '0;
        end
      endcase
    end else if (data_byte[7:6] != 2'b10) begin
      // Bad continuation: byte swallowed, sequence dropped
      step.res_valid      = 1'b1;
      step.res.error      = 1'b1;
      step.res.code_point = err_value;
      step.nxt            = '0;
    end else if (cur.pending == PEND_W'(1)) begin
      // Last continuation completes the code point
      step.res_valid      = 1'b1;
      step.res.code_point = shifted;
      step.nxt            = '0;
    end else begin
      step.nxt.partial = shifted;
      step.nxt.pending = cur.pending - PEND_W'(1);
    end

    // Stream ends mid-sequence: truncation error
    if (!step.res_valid && end_of_stream) begin
      step.res_valid      = 1'b1;
      step.res.error      = 1'b1;
      step.res.code_point = err_value;
      step.nxt            = '0;
    end
  end

endmodule
